// ----- hdl/itpm_pkg.sv -----
// itpm_pkg: constants and codes shared by the interval timer port model
// and its checker. No dependencies.
package itpm_pkg;

   localparam int CHANNELS = 3;
   localparam logic [15:0] PORT_BASE = 16'd64;
   localparam logic [15:0] CMD_PORT = PORT_BASE + 16'd3;

   localparam logic [1:0] OP_READ = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] ACC_LATCH = 2'd0;
   localparam logic [1:0] ACC_LOW = 2'd1;
   localparam logic [1:0] ACC_HIGH = 2'd2;
   localparam logic [1:0] ACC_BOTH = 2'd3;

   localparam logic [2:0] MODE_RATE = 3'd2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

endpackage

// ----- hdl/interval_timer_port_model.sv -----
// interval_timer_port_model: three-channel interval timer behind four byte ports, uses itpm_pkg
// a response is registered: it is valid in the cycle after its request is taken
// throughput: one request per cycle, all state updates in the cycle of acceptance
// a request is taken whenever the result register is empty or being drained
// reset (synchronous, active high) sets counts and reloads to 0xffff and clears mode,
// started, countdown, command word, byte toggle and response valid
module interval_timer_port_model (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // port_address[15:0], write_data[23:16]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_data[7:0], interrupt_pulse[8], zero[15:9]
);

   logic [15:0] count_ff [itpm_pkg::CHANNELS];
   logic [15:0] count_in [itpm_pkg::CHANNELS];
   logic [15:0] reload_ff [itpm_pkg::CHANNELS];
   logic [15:0] reload_in [itpm_pkg::CHANNELS];
   logic [15:0] countdown_ff [itpm_pkg::CHANNELS];
   logic [15:0] countdown_in [itpm_pkg::CHANNELS];
   logic [2:0]  mode_ff [itpm_pkg::CHANNELS];
   logic [2:0]  mode_in [itpm_pkg::CHANNELS];
   logic [itpm_pkg::CHANNELS-1:0] started_ff;
   logic [itpm_pkg::CHANNELS-1:0] started_in;
   logic [7:0]  command_ff;
   logic [7:0]  command_in;
   logic        toggle_ff;
   logic        toggle_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;

   logic        accept;
   logic [1:0]  opcode;
   logic [15:0] addr;
   logic [7:0]  wdata;
   logic [15:0] offset;
   logic        is_data;
   logic        is_cmd;
   logic [1:0]  acc;
   logic [1:0]  new_acc;
   logic [1:0]  sel;
   logic        flip;
   logic        lane_low;
   logic        lane_high;
   logic [7:0]  rd;
   logic        irq;
   logic [15:0] reload_tmp;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign opcode = req_tuser;
   assign addr = req_tdata[15:0];
   assign wdata = req_tdata[23:16];
   assign offset = addr - itpm_pkg::PORT_BASE;
   assign is_data = (addr >= itpm_pkg::PORT_BASE) && (offset < 16'(itpm_pkg::CHANNELS))
                    && (offset < 16'd3);
   assign is_cmd = (addr == itpm_pkg::CMD_PORT);
   assign acc = command_ff[5:4];
   assign new_acc = wdata[5:4];
   assign sel = wdata[7:6];
   assign flip = toggle_ff ^ 1'b1;
   assign lane_low = (acc == itpm_pkg::ACC_LOW) || ((acc == itpm_pkg::ACC_BOTH) && !flip);
   assign lane_high = (acc == itpm_pkg::ACC_HIGH) || ((acc == itpm_pkg::ACC_BOTH) && flip);

   always_comb begin
      count_in = count_ff;
      reload_in = reload_ff;
      countdown_in = countdown_ff;
      mode_in = mode_ff;
      started_in = started_ff;
      command_in = command_ff;
      toggle_in = toggle_ff;
      rd = 8'd0;
      irq = 1'b0;
      reload_tmp = 16'd0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (opcode)
            itpm_pkg::OP_READ: begin
               if (is_data) begin
                  if (acc == itpm_pkg::ACC_BOTH) begin
                     toggle_in = flip;
                  end
                  for (int i = 0; i < itpm_pkg::CHANNELS; i++) begin
                     if (offset[1:0] == 2'(i)) begin
                        if (lane_low) begin
                           rd = count_ff[i][7:0];
                        end else if (lane_high) begin
                           rd = count_ff[i][15:8];
                        end
                     end
                  end
               end
            end
            itpm_pkg::OP_WRITE: begin
               if (is_data) begin
                  if (acc == itpm_pkg::ACC_BOTH) begin
                     toggle_in = flip;
                  end
                  for (int i = 0; i < itpm_pkg::CHANNELS; i++) begin
                     if (offset[1:0] == 2'(i)) begin
                        if (lane_low) begin
                           count_in[i] = {count_ff[i][15:8], wdata};
                        end else if (lane_high) begin
                           count_in[i] = {wdata, count_ff[i][7:0]};
                        end
                        reload_in[i] = count_in[i];
                     end
                  end
               end else if (is_cmd) begin
                  command_in = wdata;
                  for (int i = 0; i < itpm_pkg::CHANNELS; i++) begin
                     if (sel == 2'(i)) begin
                        mode_in[i] = wdata[3:1];
                        reload_tmp = reload_ff[i];
                        if (new_acc == itpm_pkg::ACC_LATCH) begin
                           reload_tmp = count_ff[i];
                        end else if (new_acc == itpm_pkg::ACC_BOTH) begin
                           toggle_in = 1'b1;
                        end
                        reload_in[i] = reload_tmp;
                        if (!started_ff[i]) begin
                           started_in[i] = 1'b1;
                           countdown_in[i] = reload_tmp;
                        end
                     end
                  end
               end
            end
            itpm_pkg::OP_TICK: begin
               for (int i = 0; i < itpm_pkg::CHANNELS; i++) begin
                  if (started_ff[i]) begin
                     if (mode_ff[i] == itpm_pkg::MODE_RATE) begin
                        if (countdown_ff[i] <= 16'd1) begin
                           irq = 1'b1;
                           countdown_in[i] = reload_ff[i];
                        end else begin
                           countdown_in[i] = countdown_ff[i] - 16'd1;
                        end
                     end else begin
                        countdown_in[i] = reload_ff[i];
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         rsp_data_in = {7'd0, irq, rd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < itpm_pkg::CHANNELS; i++) begin
            count_ff[i] <= 16'hffff;
            reload_ff[i] <= 16'hffff;
            countdown_ff[i] <= 16'd0;
            mode_ff[i] <= 3'd0;
         end
         started_ff <= '0;
         command_ff <= 8'd0;
         toggle_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         reload_ff <= reload_in;
         countdown_ff <= countdown_in;
         mode_ff <= mode_in;
         started_ff <= started_in;
         command_ff <= command_in;
         toggle_ff <= toggle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hdl/itpm_checker.sv -----
// itpm_checker: port-level assertions for interval_timer_port_model, bound to it.
// Uses itpm_pkg for opcode codes.
module itpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // an empty result register never blocks a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // every request yields a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("missing response");

   // only reads return data
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser != itpm_pkg::OP_READ) |=> rsp_tdata[7:0] == 8'd0)
      else $error("read data on non-read request");

   // only ticks raise the interrupt
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser != itpm_pkg::OP_TICK) |=> !rsp_tdata[8])
      else $error("interrupt on non-tick request");

endmodule

bind interval_timer_port_model itpm_checker u_itpm_checker (.*);

// ----- tb/interval_timer_port_model_tb.sv -----
`timescale 1ns / 1ps
// interval_timer_port_model_tb: self-checking bench for the three-channel interval timer.
// Drives port reads, writes and clock ticks on the request stream and checks each response
// against an in-bench model of the timer. Depends on itpm_pkg and interval_timer_port_model.
module interval_timer_port_model_tb;

   localparam int ITEM_TARGET = 500;
   localparam int HOLD_AT = 150;
   localparam int HOLD_LEN = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [1:0] LANE_LO = 2'd0;
   localparam logic [1:0] LANE_HI = 2'd1;
   localparam logic [1:0] LANE_NONE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
   } port_req_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // port_address[15:0], write_data[23:16]
   logic [1:0]  req_tuser = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // read_data[7:0], interrupt_pulse[8], zero[15:9]

   interval_timer_port_model uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // timer model state
   logic [15:0] tm_count [3];
   logic [15:0] tm_reload [3];
   logic [2:0]  tm_mode [3];
   logic        tm_started [3];
   logic [15:0] tm_left [3];
   logic [7:0]  tm_cmd;
   logic        tm_toggle;

   port_req_type port_req_q [$];
   logic [8:0]  timer_rsp_q [$];   // {interrupt_pulse, read_data}

   int err_count = 0;
   int op_count [4] = '{0, 0, 0, 0};
   int irq_seen = 0;
   int req_sent = 0;
   int rsp_seen = 0;
   int req_wait = 0;
   int rsp_stall = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   port_req_type cur_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [1:0] timer_lane();
      logic [1:0] acc;
      acc = tm_cmd[5:4];
      if (acc == itpm_pkg::ACC_LOW) return LANE_LO;
      if (acc == itpm_pkg::ACC_HIGH) return LANE_HI;
      if (acc == itpm_pkg::ACC_BOTH) begin
         tm_toggle = ~tm_toggle;
         return tm_toggle ? LANE_HI : LANE_LO;
      end
      return LANE_NONE;
   endfunction

   function automatic logic [8:0] timer_response(input logic [1:0] op, input logic [15:0] addr,
                                                 input logic [7:0] wd);
      logic [7:0] rd;
      logic       irq;
      int         off;
      int         ch;
      logic [1:0] lane;
      logic [1:0] sel;
      rd = '0;
      irq = 1'b0;
      off = int'(addr) - int'(itpm_pkg::PORT_BASE);
      ch = (off >= 0 && off < 3 && off < itpm_pkg::CHANNELS) ? off : -1;
      case (op)
         itpm_pkg::OP_READ: begin
            if (ch >= 0) begin
               lane = timer_lane();
               if (lane == LANE_LO) rd = tm_count[ch][7:0];
               else if (lane == LANE_HI) rd = tm_count[ch][15:8];
            end
         end
         itpm_pkg::OP_WRITE: begin
            if (ch >= 0) begin
               lane = timer_lane();
               if (lane == LANE_LO) tm_count[ch][7:0] = wd;
               else if (lane == LANE_HI) tm_count[ch][15:8] = wd;
               tm_reload[ch] = tm_count[ch];
            end else if (addr == itpm_pkg::CMD_PORT) begin
               tm_cmd = wd;
               sel = wd[7:6];
               if (sel < 3 && sel < itpm_pkg::CHANNELS) begin
                  tm_mode[sel] = wd[3:1];
                  if (wd[5:4] == itpm_pkg::ACC_LATCH) tm_reload[sel] = tm_count[sel];
                  else if (wd[5:4] == itpm_pkg::ACC_BOTH) tm_toggle = 1'b1;
                  if (!tm_started[sel]) begin
                     tm_started[sel] = 1'b1;
                     tm_left[sel] = tm_reload[sel];
                  end
               end
            end
         end
         itpm_pkg::OP_TICK: begin
            for (int i = 0; i < itpm_pkg::CHANNELS && i < 3; i++) begin
               if (tm_started[i]) begin
                  if (tm_mode[i] == itpm_pkg::MODE_RATE) begin
                     if (tm_left[i] <= 16'd1) begin
                        irq = 1'b1;
                        tm_left[i] = tm_reload[i];
                     end else begin
                        tm_left[i] = tm_left[i] - 16'd1;
                     end
                  end else begin
                     tm_left[i] = tm_reload[i];
                  end
               end
            end
         end
         default: ;
      endcase
      return {irq, rd};
   endfunction

   function automatic logic [7:0] cmd_byte(input logic [1:0] sel, input logic [2:0] mode,
                                           input logic [1:0] acc);
      logic bcd;
      bcd = 1'($urandom_range(0, 1));
      return {sel, acc, mode, bcd};
   endfunction

   task automatic add_req(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data);
      port_req_type r;
      r.op = op;
      r.addr = addr;
      r.data = data;
      port_req_q.push_back(r);
   endtask

   // set a short period in a non-rate mode, then switch to a chosen mode and tick
   task automatic add_program();
      logic [1:0] ch;
      logic [2:0] mode;
      logic [1:0] acc;
      logic [7:0] lo;
      logic [7:0] hi;
      int         n;
      ch = 2'($urandom_range(0, 2));
      lo = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      hi = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd0;
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT, cmd_byte(ch, 3'd0, itpm_pkg::ACC_BOTH));
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::PORT_BASE + 16'(ch), lo);
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::PORT_BASE + 16'(ch), hi);
      add_req(itpm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
      mode = ($urandom_range(0, 2) == 0) ? 3'($urandom) : itpm_pkg::MODE_RATE;
      acc = 2'($urandom);
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT, cmd_byte(ch, mode, acc));
      n = $urandom_range(1, 14);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0)
            add_req(itpm_pkg::OP_READ, itpm_pkg::PORT_BASE + 16'($urandom_range(0, 3)),
                    8'($urandom));
         else
            add_req(itpm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
      end
   endtask

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            timer_rsp_q.push_back(timer_response(req_tuser, req_tdata[15:0], req_tdata[23:16]));
            op_count[req_tuser]++;
            req_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (port_req_q.size() != 0) begin
               cur_req = port_req_q.pop_front();
               req_tuser <= cur_req.op;
               req_tdata <= {cur_req.data, cur_req.addr};
               req_tvalid <= 1'b1;
               req_wait = ((req_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 6);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      logic [8:0] exp_rsp;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (timer_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h", $time, rsp_tdata);
               err_count++;
            end else begin
               exp_rsp = timer_rsp_q.pop_front();
               if (rsp_tdata[7:0] !== exp_rsp[7:0]) begin
                  $display("%0t: read_data mismatch, expected %h actual %h",
                           $time, exp_rsp[7:0], rsp_tdata[7:0]);
                  err_count++;
               end
               if (rsp_tdata[8] !== exp_rsp[8]) begin
                  $display("%0t: interrupt_pulse mismatch, expected %b actual %b",
                           $time, exp_rsp[8], rsp_tdata[8]);
                  err_count++;
               end
               if (rsp_tdata[15:9] !== 7'd0) begin
                  $display("%0t: padding mismatch, expected %h actual %h",
                           $time, 7'd0, rsp_tdata[15:9]);
                  err_count++;
               end
            end
            if (rsp_tdata[8] === 1'b1) irq_seen++;
            rsp_seen++;
            rsp_stall = ((rsp_seen / 50) % 4 == 1) ? 0 : $urandom_range(0, 6);
            if (rsp_seen == HOLD_AT) hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses pending",
                  $time, timer_rsp_q.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int kind;
      for (int i = 0; i < 3; i++) begin
         tm_count[i] = 16'hffff;
         tm_reload[i] = 16'hffff;
         tm_mode[i] = '0;
         tm_started[i] = 1'b0;
         tm_left[i] = '0;
      end
      tm_cmd = '0;
      tm_toggle = 1'b0;

      // access bits zero: read gives zero, write only copies count to reload
      add_req(itpm_pkg::OP_READ, itpm_pkg::PORT_BASE, 8'h00);
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::PORT_BASE, 8'hab);
      // ports outside the map and the idle opcode
      add_req(itpm_pkg::OP_READ, 16'h0000, 8'hff);
      add_req(itpm_pkg::OP_WRITE, 16'hffff, 8'hff);
      add_req(OP_NOP, itpm_pkg::CMD_PORT, 8'hff);
      add_req(itpm_pkg::OP_TICK, 16'hffff, 8'h00);
      // command for channel three only stores the command word
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
              cmd_byte(2'd3, itpm_pkg::MODE_RATE, itpm_pkg::ACC_BOTH));
      add_req(itpm_pkg::OP_READ, itpm_pkg::PORT_BASE + 16'd1, 8'h00);
      // channel 0: short period in mode 0, then rate mode and run to expiry
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT, cmd_byte(2'd0, 3'd0, itpm_pkg::ACC_BOTH));
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::PORT_BASE, 8'h03);
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::PORT_BASE, 8'h00);
      add_req(itpm_pkg::OP_TICK, 16'h0000, 8'h00);
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
              cmd_byte(2'd0, itpm_pkg::MODE_RATE, itpm_pkg::ACC_BOTH));
      add_req(itpm_pkg::OP_READ, itpm_pkg::PORT_BASE, 8'h00);
      add_req(itpm_pkg::OP_READ, itpm_pkg::PORT_BASE, 8'h00);
      add_req(itpm_pkg::OP_TICK, 16'h0000, 8'h00);
      add_req(itpm_pkg::OP_TICK, 16'h0000, 8'h00);
      add_req(itpm_pkg::OP_TICK, 16'h0000, 8'h00);
      // setting a reload of one leaves the running countdown as it is; the ticks count it down
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
              cmd_byte(2'd0, itpm_pkg::MODE_RATE, itpm_pkg::ACC_LOW));
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::PORT_BASE, 8'h01);
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
              cmd_byte(2'd0, itpm_pkg::MODE_RATE, itpm_pkg::ACC_LATCH));
      add_req(itpm_pkg::OP_TICK, 16'h0000, 8'h00);
      add_req(itpm_pkg::OP_TICK, 16'h0000, 8'h00);
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT, cmd_byte(2'd2, 3'd7, itpm_pkg::ACC_HIGH));
      add_req(itpm_pkg::OP_WRITE, itpm_pkg::PORT_BASE + 16'd2, 8'h00);

      while (port_req_q.size() < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            add_program();
         end else if (kind <= 7) begin
            add_req(2'($urandom_range(0, 1)), itpm_pkg::PORT_BASE + 16'($urandom_range(0, 3)),
                    8'($urandom));
         end else if (kind == 8) begin
            add_req(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8)) add_req(itpm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (port_req_q.size() != 0 || req_tvalid || timer_rsp_q.size() != 0);
      repeat (4) @(negedge clock);

      $display("covered %0d reads, %0d writes, %0d ticks, %0d idle opcodes",
               op_count[itpm_pkg::OP_READ], op_count[itpm_pkg::OP_WRITE],
               op_count[itpm_pkg::OP_TICK], op_count[OP_NOP]);
      $display("%0d responses checked, %0d interrupt pulses, %0d errors",
               rsp_seen, irq_seen, err_count);
      if (err_count == 0 && timer_rsp_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/itpm_pkg.sv
hdl/interval_timer_port_model.sv
hdl/itpm_checker.sv
tb/interval_timer_port_model_tb.sv
